[design/lns_pkg.sv]
// ---------------------------------------------------------------------------
// lns_pkg: shared types and constants of the lognormal score unit
// Payload structs, the division cell record and the logarithm table.
// ---------------------------------------------------------------------------
`default_nettype none

package lns_pkg;

  localparam int LOG_ADDR_BITS = 8;
  localparam int OUT_FRAC_BITS = 32;
  localparam int TABLE_LEN     = (1 << LOG_ADDR_BITS) + 1;
  localparam int REM_BITS      = 31 - LOG_ADDR_BITS;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam int QUO_BITS  = 64;
  localparam int DEN_BITS  = 96;
  localparam int NUM_LANES = 5;

  localparam int LANE_GL  = 0;
  localparam int LANE_GS  = 1;
  localparam int LANE_HLL = 2;
  localparam int LANE_HSS = 3;
  localparam int LANE_HLS = 4;

  localparam logic [2:0] REG_SHARED_LOC = 3'd0;
  localparam logic [2:0] REG_SHARED_SSQ = 3'd1;
  localparam logic [2:0] REG_USE_LOC    = 3'd2;
  localparam logic [2:0] REG_USE_SSQ    = 3'd3;
  localparam logic [2:0] REG_HESS_KIND  = 3'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_SAT     = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic        [31:0] sample;
    logic signed [31:0] location;
    logic        [31:0] scale_sq;
  } in_t;

  typedef struct packed {
    logic signed [63:0] grad_location;
    logic signed [63:0] grad_scale_sq;
    logic signed [63:0] hess_loc_loc;
    logic signed [63:0] hess_scale_scale;
    logic signed [63:0] hess_loc_scale;
    logic        [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [DEN_BITS-1:0] rem;
    logic [DEN_BITS-1:0] den;
    logic [QUO_BITS-1:0] nq;   // numerator bits out at the top, quotient bits in at the bottom
    logic                neg;
    logic                ovf;
  } lane_t;

  typedef struct packed {
    logic                     invalid;
    lane_t [NUM_LANES-1:0]    lane;
  } cell_t;

  typedef logic [31:0] ln_table_t [TABLE_LEN];

  function automatic ln_table_t build_ln_table();
    ln_table_t   t;
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] p;
    for (int k = 0; k < TABLE_LEN - 1; k++) begin
      x = 64'h8000_0000 + (64'(k) << REM_BITS);
      r = '0;
      for (int i = 31; i >= 0; i--) begin
        x = (x * x) >> 31;
        if (x >= 64'h1_0000_0000) begin
          x = x >> 1;
          r[i] = 1'b1;
        end
      end
      p = r * {32'd0, LN2_Q32};
      t[k] = p[63:32];
    end
    t[TABLE_LEN-1] = LN2_Q32;
    return t;
  endfunction

  localparam ln_table_t LN_TABLE = build_ln_table();

endpackage

`default_nettype wire

[design/lognormal_score_and_hessian.sv]
// ---------------------------------------------------------------------------
// lognormal_score_and_hessian: lognormal gradient and Hessian unit
//
// An item transfers on a rising edge with start high and busy low; busy is
// always low, so one item can enter every cycle. Each item carries a sample
// y (Q16.16), a location mu (Q8.24) and a variance sigma2 (Q8.24); mu and
// sigma2 may be taken from the shared registers instead.
// The result stands on result_o for one cycle with done_o high, past six setup
// stages (log table, residual, squares), 64 division cells that each yield one
// quotient bit, and a finishing stage. The division cell chain sets the
// latency; throughput is one item per cycle. Configuration writes transfer
// when cfg_valid_i and cfg_ready_o are high; cfg_ready_o is always high. The
// user must change registers only while idle; the block does not enforce it.
// Reset clears the pipeline and loads the register defaults; results in flight
// are dropped. The receiver cannot stall; no results are held back.
// ---------------------------------------------------------------------------
`default_nettype none

module lognormal_score_and_hessian (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire lns_pkg::in_t  in_data_i,
  output logic               done_o,
  output lns_pkg::out_t      result_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i
);

  logic [31:0] shared_loc_q, shared_ssq_q;
  logic        use_loc_q, use_ssq_q, hess_kind_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shared_loc_q <= '0;
      shared_ssq_q <= 32'd16777216;
      use_loc_q    <= 1'b0;
      use_ssq_q    <= 1'b0;
      hess_kind_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lns_pkg::REG_SHARED_LOC: shared_loc_q <= cfg_data_i;
        lns_pkg::REG_SHARED_SSQ: shared_ssq_q <= cfg_data_i;
        lns_pkg::REG_USE_LOC:    use_loc_q    <= cfg_data_i[0];
        lns_pkg::REG_USE_SSQ:    use_ssq_q    <= cfg_data_i[0];
        lns_pkg::REG_HESS_KIND:  hess_kind_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic           vld [lns_pkg::QUO_BITS+1];
  lns_pkg::cell_t dat [lns_pkg::QUO_BITS+1];

  lns_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .in_data_i    (in_data_i),
    .shared_loc_i (shared_loc_q),
    .shared_ssq_i (shared_ssq_q),
    .use_loc_i    (use_loc_q),
    .use_ssq_i    (use_ssq_q),
    .hess_kind_i  (hess_kind_q),
    .valid_o      (vld[0]),
    .data_o       (dat[0])
  );

  for (genvar g = 0; g < lns_pkg::QUO_BITS; g++) begin : g_cell
    lns_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .data_i  (dat[g]),
      .valid_o (vld[g+1]),
      .data_o  (dat[g+1])
    );
  end

  lns_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld[lns_pkg::QUO_BITS]),
    .data_i   (dat[lns_pkg::QUO_BITS]),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

[design/lns_front.sv]
// ---------------------------------------------------------------------------
// lns_front: logarithm, residual and operand setup
// Six registered stages from the accepted item to the division lanes.
// ---------------------------------------------------------------------------
`default_nettype none

module lns_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire lns_pkg::in_t  in_data_i,
  input  wire logic [31:0]   shared_loc_i,
  input  wire logic [31:0]   shared_ssq_i,
  input  wire logic          use_loc_i,
  input  wire logic          use_ssq_i,
  input  wire logic          hess_kind_i,
  output logic               valid_o,
  output lns_pkg::cell_t     data_o
);

  localparam int A = lns_pkg::LOG_ADDR_BITS;
  localparam int R = lns_pkg::REM_BITS;
  localparam int F = lns_pkg::OUT_FRAC_BITS;

  // stage a: operand select
  logic               a_valid_q;
  logic [31:0]        a_y_q, a_s_q;
  logic signed [31:0] a_mu_q;
  logic               a_kind_q, a_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_valid_q <= 1'b0;
    else         a_valid_q <= start;
  end

  always_ff @(posedge clk_i) begin
    a_y_q    <= in_data_i.sample;
    a_mu_q   <= use_loc_i ? $signed(shared_loc_i) : in_data_i.location;
    a_s_q    <= use_ssq_i ? shared_ssq_i : in_data_i.scale_sq;
    a_kind_q <= hess_kind_i;
    a_inv_q  <= (in_data_i.sample == '0) ||
                ((use_ssq_i ? shared_ssq_i : in_data_i.scale_sq) == '0);
  end

  // stage b: normalize, table read, variance square
  logic [4:0]  p_c;
  logic [31:0] m_c;
  logic [A-1:0] k_c;
  logic [31:0] lo_c, hi_c;

  always_comb begin
    p_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (a_y_q[i]) p_c = 5'(i);
    end
    m_c  = a_y_q << (5'd31 - p_c);
    k_c  = m_c[30 -: A];
    lo_c = lns_pkg::LN_TABLE[k_c];
    hi_c = lns_pkg::LN_TABLE[{1'b0, k_c} + 1'b1];
  end

  logic               b_valid_q;
  logic [4:0]         b_p_q;
  logic [31:0]        b_lo_q, b_diff_q, b_s_q;
  logic [R-1:0]       b_r_q;
  logic [63:0]        b_ssq_q;
  logic signed [31:0] b_mu_q;
  logic               b_kind_q, b_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_valid_q <= 1'b0;
    else         b_valid_q <= a_valid_q;
  end

  always_ff @(posedge clk_i) begin
    b_p_q    <= p_c;
    b_lo_q   <= lo_c;
    b_diff_q <= hi_c - lo_c;
    b_r_q    <= m_c[R-1:0];
    b_ssq_q  <= {32'd0, a_s_q} * {32'd0, a_s_q};
    b_s_q    <= a_s_q;
    b_mu_q   <= a_mu_q;
    b_kind_q <= a_kind_q;
    b_inv_q  <= a_inv_q;
  end

  // stage c: interpolation product, exponent term, cube partials
  logic               c_valid_q;
  logic [31+R:0]      c_prod_q;
  logic signed [37:0] c_e_q;
  logic [31:0]        c_lo_q, c_s_q;
  logic [63:0]        c_s3lo_q, c_s3hi_q, c_ssq_q;
  logic signed [31:0] c_mu_q;
  logic               c_kind_q, c_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_valid_q <= 1'b0;
    else         c_valid_q <= b_valid_q;
  end

  always_ff @(posedge clk_i) begin
    c_prod_q <= {{R{1'b0}}, b_diff_q} * {32'd0, b_r_q};
    c_e_q    <= 38'($signed({1'b0, b_p_q}) - 6'sd16) * $signed({6'd0, lns_pkg::LN2_Q32});
    c_lo_q   <= b_lo_q;
    c_s3lo_q <= {32'd0, b_ssq_q[31:0]} * {32'd0, b_s_q};
    c_s3hi_q <= {32'd0, b_ssq_q[63:32]} * {32'd0, b_s_q};
    c_ssq_q  <= b_ssq_q;
    c_s_q    <= b_s_q;
    c_mu_q   <= b_mu_q;
    c_kind_q <= b_kind_q;
    c_inv_q  <= b_inv_q;
  end

  // stage d: ln rounding to q.24, residual and its magnitude
  logic [32:0]        frac_c;
  logic signed [37:0] v_c;
  logic signed [33:0] res_c;
  logic [33:0]        ar_c;

  always_comb begin
    frac_c = {1'b0, c_lo_q} + 33'(c_prod_q >> R);
    v_c    = c_e_q + $signed({5'd0, frac_c}) + 38'sd128;
    res_c  = 34'($signed(v_c[37:8])) - 34'(c_mu_q);
    ar_c   = res_c[33] ? 34'(-res_c) : res_c;
  end

  logic        d_valid_q;
  logic [31:0] d_ar_q, d_s_q;
  logic        d_rneg_q, d_kind_q, d_inv_q;
  logic [95:0] d_s3_q;
  logic [63:0] d_ssq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_valid_q <= 1'b0;
    else         d_valid_q <= c_valid_q;
  end

  always_ff @(posedge clk_i) begin
    d_ar_q   <= ar_c[31:0];
    d_rneg_q <= res_c[33];
    d_s3_q   <= {32'd0, c_s3lo_q} + {c_s3hi_q, 32'd0};
    d_ssq_q  <= c_ssq_q;
    d_s_q    <= c_s_q;
    d_kind_q <= c_kind_q;
    d_inv_q  <= c_inv_q;
  end

  // stage e: residual square
  logic        e_valid_q;
  logic [63:0] e_r2_q, e_ssq_q;
  logic [31:0] e_ar_q, e_s_q;
  logic        e_rneg_q, e_kind_q, e_inv_q;
  logic [95:0] e_s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_valid_q <= 1'b0;
    else         e_valid_q <= d_valid_q;
  end

  always_ff @(posedge clk_i) begin
    e_r2_q   <= {32'd0, d_ar_q} * {32'd0, d_ar_q};
    e_ar_q   <= d_ar_q;
    e_rneg_q <= d_rneg_q;
    e_s3_q   <= d_s3_q;
    e_ssq_q  <= d_ssq_q;
    e_s_q    <= d_s_q;
    e_kind_q <= d_kind_q;
    e_inv_q  <= d_inv_q;
  end

  // stage f: numerators, denominators, signs and overflow precheck
  logic [63:0]  s24_c, two_r2_c, d1_c, d3_c;
  logic         n1_c, n3_c;
  logic [127:0] num_c [lns_pkg::NUM_LANES];
  logic [95:0]  den_c [lns_pkg::NUM_LANES];
  logic         neg_c [lns_pkg::NUM_LANES];
  lns_pkg::cell_t f_c;

  always_comb begin
    s24_c    = {8'd0, e_s_q, 24'd0};
    two_r2_c = {e_r2_q[62:0], 1'b0};
    n1_c     = e_r2_q < s24_c;
    d1_c     = n1_c ? s24_c - e_r2_q : e_r2_q - s24_c;
    n3_c     = s24_c < two_r2_c;
    d3_c     = n3_c ? two_r2_c - s24_c : s24_c - two_r2_c;

    num_c[lns_pkg::LANE_GL]  = {96'd0, e_ar_q} << F;
    den_c[lns_pkg::LANE_GL]  = {64'd0, e_s_q};
    neg_c[lns_pkg::LANE_GL]  = e_rneg_q;
    num_c[lns_pkg::LANE_GS]  = {64'd0, d1_c} << (F - 1);
    den_c[lns_pkg::LANE_GS]  = {32'd0, e_ssq_q};
    neg_c[lns_pkg::LANE_GS]  = n1_c;
    num_c[lns_pkg::LANE_HLL] = 128'd1 << (24 + F);
    den_c[lns_pkg::LANE_HLL] = {64'd0, e_s_q};
    neg_c[lns_pkg::LANE_HLL] = 1'b1;
    if (e_kind_q) begin
      num_c[lns_pkg::LANE_HSS] = 128'd1 << (47 + F);
      den_c[lns_pkg::LANE_HSS] = {32'd0, e_ssq_q};
      neg_c[lns_pkg::LANE_HSS] = 1'b1;
      num_c[lns_pkg::LANE_HLS] = '0;
      neg_c[lns_pkg::LANE_HLS] = 1'b0;
    end else begin
      num_c[lns_pkg::LANE_HSS] = {64'd0, d3_c} << (23 + F);
      den_c[lns_pkg::LANE_HSS] = e_s3_q;
      neg_c[lns_pkg::LANE_HSS] = n3_c;
      num_c[lns_pkg::LANE_HLS] = {96'd0, e_ar_q} << (24 + F);
      neg_c[lns_pkg::LANE_HLS] = !e_rneg_q && (e_ar_q != '0);
    end
    den_c[lns_pkg::LANE_HLS] = {32'd0, e_ssq_q};

    f_c.invalid = e_inv_q;
    for (int l = 0; l < lns_pkg::NUM_LANES; l++) begin
      f_c.lane[l].rem = {32'd0, num_c[l][127:64]};
      f_c.lane[l].den = den_c[l];
      f_c.lane[l].nq  = num_c[l][63:0];
      f_c.lane[l].neg = neg_c[l];
      // quotient of 2^64 or more
      f_c.lane[l].ovf = {32'd0, num_c[l][127:64]} >= den_c[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= e_valid_q;
  end

  always_ff @(posedge clk_i) begin
    data_o <= f_c;
  end

endmodule

`default_nettype wire

[design/lns_div_cell.sv]
// ---------------------------------------------------------------------------
// lns_div_cell: one restoring division step for all five lanes
// Produces one quotient bit per lane and hands the record to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module lns_div_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire lns_pkg::cell_t  data_i,
  output logic                 valid_o,
  output lns_pkg::cell_t       data_o
);

  localparam int W = lns_pkg::DEN_BITS;
  localparam int Q = lns_pkg::QUO_BITS;

  lns_pkg::cell_t nxt_c;
  logic [W:0]     t_c;
  logic           b_c;

  always_comb begin
    nxt_c = data_i;
    t_c   = '0;
    b_c   = 1'b0;
    for (int l = 0; l < lns_pkg::NUM_LANES; l++) begin
      t_c = {data_i.lane[l].rem, data_i.lane[l].nq[Q-1]};
      b_c = t_c >= {1'b0, data_i.lane[l].den};
      if (b_c) t_c = t_c - {1'b0, data_i.lane[l].den};
      nxt_c.lane[l].rem = t_c[W-1:0];
      nxt_c.lane[l].nq  = {data_i.lane[l].nq[Q-2:0], b_c};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    data_o <= nxt_c;
  end

endmodule

`default_nettype wire

[design/lns_finish.sv]
// ---------------------------------------------------------------------------
// lns_finish: sign, saturation and status of the five quotients
// Registers the result record and its strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module lns_finish (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire lns_pkg::cell_t  data_i,
  output logic                 done_o,
  output lns_pkg::out_t        result_o
);

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  logic [63:0]   val_c [lns_pkg::NUM_LANES];
  logic          sat_c [lns_pkg::NUM_LANES];
  logic [63:0]   q_c;
  logic          any_sat_c;
  lns_pkg::out_t res_c;

  always_comb begin
    any_sat_c = 1'b0;
    q_c       = '0;
    for (int l = 0; l < lns_pkg::NUM_LANES; l++) begin
      q_c = data_i.lane[l].nq;
      sat_c[l] = data_i.lane[l].ovf ||
                 (data_i.lane[l].neg ? (q_c[63] && (q_c[62:0] != '0)) : q_c[63]);
      if (sat_c[l])                val_c[l] = data_i.lane[l].neg ? NEG_MIN : POS_MAX;
      else if (data_i.lane[l].neg) val_c[l] = 64'(-q_c);
      else                         val_c[l] = q_c;
      any_sat_c = any_sat_c | sat_c[l];
    end
    if (data_i.invalid) begin
      res_c        = '0;
      res_c.status = lns_pkg::STATUS_INVALID;
    end else begin
      res_c.grad_location    = val_c[lns_pkg::LANE_GL];
      res_c.grad_scale_sq    = val_c[lns_pkg::LANE_GS];
      res_c.hess_loc_loc     = val_c[lns_pkg::LANE_HLL];
      res_c.hess_scale_scale = val_c[lns_pkg::LANE_HSS];
      res_c.hess_loc_scale   = val_c[lns_pkg::LANE_HLS];
      res_c.status           = any_sat_c ? lns_pkg::STATUS_SAT : lns_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    result_o <= res_c;
  end

endmodule

`default_nettype wire

[tb/lognormal_score_and_hessian_test.sv]
// ---------------------------------------------------------------------------
// lognormal_score_and_hessian_test: self-checking bench for the score unit
// Directed and random samples go through the unit under several register
// settings; each result is checked field by field against an in-bench model.
// ---------------------------------------------------------------------------
`default_nettype none

module lognormal_score_and_hessian_test;

  localparam int LATENCY = 71;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  lns_pkg::in_t in_data_i = '0;
  logic done_o;
  lns_pkg::out_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  lognormal_score_and_hessian u_dut (
    .clk_i, .rst_ni, .start, .busy, .in_data_i, .done_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // register copy for the model
  logic [31:0] m_shared_loc = '0;
  logic [31:0] m_shared_ssq = 32'd16777216;
  logic m_use_loc = 1'b0, m_use_ssq = 1'b0, m_hess_kind = 1'b0;
  logic [31:0] ln_tbl [lns_pkg::TABLE_LEN];

  lns_pkg::in_t  pending_items[$];
  lns_pkg::out_t expected_scores[$];
  int   n_errors = 0, n_checked = 0, n_sent = 0, n_invalid = 0, n_sat = 0;
  bit   quiet = 1'b0;

  function automatic void fill_ln_tbl();
    logic [63:0] x, r, p;
    for (int k = 0; k < lns_pkg::TABLE_LEN - 1; k++) begin
      x = 64'h8000_0000 + (64'(k) << (31 - lns_pkg::LOG_ADDR_BITS));
      r = '0;
      for (int i = 31; i >= 0; i--) begin
        x = (x * x) >> 31;
        if (x >= 64'h1_0000_0000) begin
          x = x >> 1;
          r[i] = 1'b1;
        end
      end
      p = r * 64'(lns_pkg::LN2_Q32);
      ln_tbl[k] = p[63:32];
    end
    ln_tbl[lns_pkg::TABLE_LEN-1] = lns_pkg::LN2_Q32;
  endfunction

  function automatic logic signed [63:0] ln_q24(logic [31:0] y);
    int p;
    logic [31:0] m;
    logic [63:0] k, r, lo, hi, frac;
    logic signed [63:0] v;
    logic [63:0] u;
    p = 31;
    while (p > 0 && y[p] == 1'b0) p--;
    m = y << (31 - p);
    k = 64'(m >> (31 - lns_pkg::LOG_ADDR_BITS)) & ((64'd1 << lns_pkg::LOG_ADDR_BITS) - 1);
    r = 64'(m) & ((64'd1 << (31 - lns_pkg::LOG_ADDR_BITS)) - 1);
    lo = 64'(ln_tbl[k]);
    hi = 64'(ln_tbl[k+1]);
    frac = lo + (((hi - lo) * r) >> (31 - lns_pkg::LOG_ADDR_BITS));
    v = 64'(signed'(p - 16)) * 64'sd2977044472 + signed'(frac);
    u = (64'(v + (64'sd1 <<< 40)) + 64'd128) >> 8;
    return signed'(u) - (64'sd1 <<< 32);
  endfunction

  function automatic logic [63:0] sat_quot(bit neg, logic [127:0] num, logic [127:0] den,
                                           ref bit sat);
    logic [127:0] q;
    logic [63:0] lim;
    q = num / den;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (q > 128'(lim)) begin
      sat = 1'b1;
      return lim;
    end
    return neg ? -q[63:0] : q[63:0];
  endfunction

  function automatic lns_pkg::out_t predict_score(lns_pkg::in_t it);
    lns_pkg::out_t o;
    logic [31:0] y, s;
    logic signed [63:0] mu, res;
    logic [63:0] ar, r2, s24, s_sq, d, two_r2;
    logic [127:0] den1, den2, den3;
    bit sat, rneg, neg;
    o = '0;
    sat = 1'b0;
    y = it.sample;
    mu = 64'(signed'(m_use_loc ? m_shared_loc : it.location));
    s = m_use_ssq ? m_shared_ssq : it.scale_sq;
    if (y == 0 || s == 0) begin
      o.status = lns_pkg::STATUS_INVALID;
      return o;
    end
    res = ln_q24(y) - mu;
    rneg = res < 0;
    ar = rneg ? -res : res;
    r2 = ar * ar;
    s24 = 64'(s) << 24;
    s_sq = 64'(s) * 64'(s);
    den1 = 128'(s);
    den2 = 128'(s_sq);
    den3 = 128'(s_sq) * 128'(s);
    o.grad_location = sat_quot(rneg, 128'(ar) << lns_pkg::OUT_FRAC_BITS, den1, sat);
    neg = r2 < s24;
    d = neg ? s24 - r2 : r2 - s24;
    o.grad_scale_sq = sat_quot(neg, 128'(d) << (lns_pkg::OUT_FRAC_BITS - 1), den2, sat);
    o.hess_loc_loc = sat_quot(1'b1, 128'd1 << (24 + lns_pkg::OUT_FRAC_BITS), den1, sat);
    if (m_hess_kind) begin
      o.hess_scale_scale = sat_quot(1'b1, 128'd1 << (47 + lns_pkg::OUT_FRAC_BITS),
                                    den2, sat);
      o.hess_loc_scale = '0;
    end else begin
      two_r2 = r2 << 1;
      neg = s24 < two_r2;
      d = neg ? two_r2 - s24 : s24 - two_r2;
      o.hess_scale_scale = sat_quot(neg, 128'(d) << (23 + lns_pkg::OUT_FRAC_BITS),
                                    den3, sat);
      o.hess_loc_scale = sat_quot(!rneg && ar != 0,
                                  128'(ar) << (24 + lns_pkg::OUT_FRAC_BITS), den2, sat);
    end
    o.status = sat ? lns_pkg::STATUS_SAT : lns_pkg::STATUS_OK;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  // driver: present the head of the queue, with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 18)) begin
        start <= 1'b1;
        in_data_i <= pending_items[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // each transfer predicts the result at the moment it is accepted
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      expected_scores.push_back(predict_score(in_data_i));
      void'(pending_items.pop_front());
      n_sent++;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    lns_pkg::out_t w;
    if (rst_ni && done_o) begin
      if (expected_scores.size() == 0) begin
        $display("result with no pending expectation");
        n_errors++;
      end else begin
        w = expected_scores.pop_front();
        n_checked++;
        if (w.status == lns_pkg::STATUS_INVALID) n_invalid++;
        if (w.status == lns_pkg::STATUS_SAT) n_sat++;
        if (result_o.grad_location !== w.grad_location)
          report_mismatch("grad_location", result_o.grad_location, w.grad_location);
        if (result_o.grad_scale_sq !== w.grad_scale_sq)
          report_mismatch("grad_scale_sq", result_o.grad_scale_sq, w.grad_scale_sq);
        if (result_o.hess_loc_loc !== w.hess_loc_loc)
          report_mismatch("hess_loc_loc", result_o.hess_loc_loc, w.hess_loc_loc);
        if (result_o.hess_scale_scale !== w.hess_scale_scale)
          report_mismatch("hess_scale_scale", result_o.hess_scale_scale,
                          w.hess_scale_scale);
        if (result_o.hess_loc_scale !== w.hess_loc_scale)
          report_mismatch("hess_loc_scale", result_o.hess_loc_scale, w.hess_loc_scale);
        if (result_o.status !== w.status)
          report_mismatch("status", 64'(result_o.status), 64'(w.status));
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      lns_pkg::REG_SHARED_LOC: m_shared_loc = val;
      lns_pkg::REG_SHARED_SSQ: m_shared_ssq = val;
      lns_pkg::REG_USE_LOC:    m_use_loc = val[0];
      lns_pkg::REG_USE_SSQ:    m_use_ssq = val[0];
      lns_pkg::REG_HESS_KIND:  m_hess_kind = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_scores.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'd1 << $urandom_range(31);
      1: return $urandom_range(32'h0002_0000, 32'h0000_4000);
      2: return 32'hFFFF_FFFF - $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_ssq();
    case ($urandom_range(5))
      0: return $urandom_range(16);
      1: return 32'd1 << $urandom_range(31);
      2: return $urandom_range(32'h0400_0000, 32'h0010_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic lns_pkg::in_t rand_item();
    lns_pkg::in_t it;
    it.sample = ($urandom_range(99) < 2) ? 32'd0 : rand_sample();
    it.location = ($urandom_range(3) == 0) ? $urandom_range(32'h0800_0000)
                  - 32'h0400_0000 : $urandom();
    it.scale_sq = ($urandom_range(99) < 2) ? 32'd0 : rand_ssq();
    return it;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_items.push_back(rand_item());
  endtask

  initial begin
    lns_pkg::in_t it;
    fill_ln_tbl();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, invalid inputs, unit values
    it = '{32'h0001_0000, 32'sd0, 32'h0100_0000}; pending_items.push_back(it);
    it = '{32'd0, 32'sd0, 32'h0100_0000}; pending_items.push_back(it);
    it = '{32'h0001_0000, 32'sd0, 32'd0}; pending_items.push_back(it);
    it = '{32'd0, 32'sd0, 32'd0}; pending_items.push_back(it);
    it = '{32'd1, 32'h7FFF_FFFF, 32'd1}; pending_items.push_back(it);
    it = '{32'hFFFF_FFFF, 32'h8000_0000, 32'd1}; pending_items.push_back(it);
    it = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF}; pending_items.push_back(it);
    it = '{32'd1, 32'h8000_0000, 32'hFFFF_FFFF}; pending_items.push_back(it);
    it = '{32'h0002_B7E1, 32'h0100_0000, 32'h0100_0000}; pending_items.push_back(it);
    it = '{32'h8000_0000, 32'sd0, 32'h0000_0100}; pending_items.push_back(it);
    it = '{32'h0000_8000, 32'hFF00_0000, 32'h4000_0000}; pending_items.push_back(it);
    drain();

    write_reg(lns_pkg::REG_HESS_KIND, 32'd1);
    for (int i = 0; i < 10; i++) pending_items.push_back(rand_item());
    it = '{32'h0001_0000, 32'sd0, 32'd1}; pending_items.push_back(it);
    it = '{32'h0001_0000, 32'sd0, 32'hFFFF_FFFF}; pending_items.push_back(it);
    drain();

    // long stretch without gaps, observed mode
    write_reg(lns_pkg::REG_HESS_KIND, 32'd0);
    quiet = 1'b1;
    random_phase(300);
    drain();
    quiet = 1'b0;
    random_phase(400);
    drain();

    write_reg(lns_pkg::REG_SHARED_LOC, 32'h8000_0000);
    write_reg(lns_pkg::REG_USE_LOC, 32'd1);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF); // unknown index, no effect
    random_phase(200);
    drain();

    write_reg(lns_pkg::REG_SHARED_LOC, 32'h7FFF_FFFF);
    write_reg(lns_pkg::REG_SHARED_SSQ, 32'hFFFF_FFFF);
    write_reg(lns_pkg::REG_USE_SSQ, 32'd1);
    write_reg(lns_pkg::REG_HESS_KIND, 32'd1);
    random_phase(200);
    drain();

    write_reg(lns_pkg::REG_SHARED_SSQ, 32'd0);
    write_reg(lns_pkg::REG_USE_LOC, 32'd0);
    random_phase(50);
    drain();

    write_reg(lns_pkg::REG_SHARED_SSQ, 32'd1);
    write_reg(lns_pkg::REG_SHARED_LOC, $urandom());
    write_reg(lns_pkg::REG_HESS_KIND, 32'd0);
    random_phase(200);
    drain();

    write_reg(lns_pkg::REG_USE_SSQ, 32'd0);
    write_reg(lns_pkg::REG_USE_LOC, 32'd1);
    write_reg(lns_pkg::REG_HESS_KIND, 32'd1);
    random_phase(250);
    drain();

    $display("checked %0d results from %0d items: %0d invalid, %0d saturated",
             n_checked, n_sent, n_invalid, n_sat);
    if (n_errors == 0 && expected_scores.size() == 0) begin
      $display("lognormal_score_and_hessian_test OK");
    end else begin
      $display("lognormal_score_and_hessian_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("lognormal_score_and_hessian_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
design/lns_pkg.sv
design/lns_front.sv
design/lns_div_cell.sv
design/lns_finish.sv
design/lognormal_score_and_hessian.sv
tb/lognormal_score_and_hessian_test.sv
